// ===== rtl/hsvbc_pkg.sv =====
// Shared types and constants for the HSV window blob centroid block.
`timescale 1ns / 1ps
package hsvbc_pkg;

    // Frame geometry: coordinates at or beyond these are clamped
    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int SUM_W   = 10;
    localparam int COUNT_W = 21;
    localparam int ACC_W   = 30;
    localparam int FRAC_W  = 4;
    localparam int CENT_W  = 14;
    localparam int QUO_W   = ACC_W + FRAC_W;
    localparam int STEP_W  = $clog2(QUO_W + 1);

    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [CENT_W-1:0]  CENT_MAX  = {CENT_W{1'b1}};

    // Window reset values
    localparam logic [PIX_W-1:0] HUE_LOW_RST  = 8'd96;
    localparam logic [PIX_W-1:0] HUE_HIGH_RST = 8'd131;
    localparam logic [PIX_W-1:0] SAT_LOW_RST  = 8'd120;
    localparam logic [PIX_W-1:0] SAT_HIGH_RST = 8'd255;
    localparam logic [PIX_W-1:0] VAL_LOW_RST  = 8'd139;
    localparam logic [PIX_W-1:0] VAL_HIGH_RST = 8'd255;

    // Classified pixel queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HUE_LOW  = 3'd0,
        CFG_HUE_HIGH = 3'd1,
        CFG_SAT_LOW  = 3'd2,
        CFG_SAT_HIGH = 3'd3,
        CFG_VAL_LOW  = 3'd4,
        CFG_VAL_HIGH = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SUM_W-1:0]   color_sum;
        logic               eof;
    } t_pix_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        BK_ACCUM,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

// ===== rtl/hsvbc_front.sv =====
// Front end: window registers, pixel classification and queue push.
`timescale 1ns / 1ps
module hsvbc_front
    import hsvbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [PIX_W-1:0]      i_cfg_wdata,
    input  logic                  i_valid,
    input  logic [PIX_W-1:0]      i_hue,
    input  logic [PIX_W-1:0]      i_sat,
    input  logic [PIX_W-1:0]      i_val,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [COORD_W-1:0]    i_col,
    input  logic                  i_eof,
    output logic                  o_ready,
    input  t_queue_status         i_q_status,
    output logic                  o_push,
    output t_pix_entry            o_entry
);

    localparam int EXT_W = 13;
    localparam logic [EXT_W-1:0] ROW_LIMIT = EXT_W'(MAX_ROWS - 1);
    localparam logic [EXT_W-1:0] COL_LIMIT = EXT_W'(MAX_COLS - 1);

    logic [PIX_W-1:0] r_hue_low, r_hue_high;
    logic [PIX_W-1:0] r_sat_low, r_sat_high;
    logic [PIX_W-1:0] r_val_low, r_val_high;

    logic [EXT_W-1:0] row_ext, col_ext, row_clamped, col_clamped;
    logic             in_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= HUE_LOW_RST;
            r_hue_high <= HUE_HIGH_RST;
            r_sat_low  <= SAT_LOW_RST;
            r_sat_high <= SAT_HIGH_RST;
            r_val_low  <= VAL_LOW_RST;
            r_val_high <= VAL_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_HUE_LOW:  r_hue_low  <= i_cfg_wdata;
                CFG_HUE_HIGH: r_hue_high <= i_cfg_wdata;
                CFG_SAT_LOW:  r_sat_low  <= i_cfg_wdata;
                CFG_SAT_HIGH: r_sat_high <= i_cfg_wdata;
                CFG_VAL_LOW:  r_val_low  <= i_cfg_wdata;
                CFG_VAL_HIGH: r_val_high <= i_cfg_wdata;
                default: ;  // ignore writes beyond the register list
            endcase
        end
    end

    always_comb begin
        in_win = (i_hue >= r_hue_low) && (i_hue <= r_hue_high) &&
                 (i_sat >= r_sat_low) && (i_sat <= r_sat_high) &&
                 (i_val >= r_val_low) && (i_val <= r_val_high);

        row_ext     = EXT_W'(i_row);
        col_ext     = EXT_W'(i_col);
        row_clamped = (row_ext > ROW_LIMIT) ? ROW_LIMIT : row_ext;
        col_clamped = (col_ext > COL_LIMIT) ? COL_LIMIT : col_ext;

        o_ready = !i_q_status.full;
        o_push  = i_valid && !i_q_status.full;

        o_entry.hit       = in_win;
        o_entry.row       = row_clamped[COORD_W-1:0];
        o_entry.col       = col_clamped[COORD_W-1:0];
        o_entry.color_sum = SUM_W'(i_hue) + SUM_W'(i_sat) + SUM_W'(i_val);
        o_entry.eof       = i_eof;
    end

endmodule

// ===== rtl/hsvbc_queue.sv =====
// Short queue of classified pixels between front and back end.
`timescale 1ns / 1ps
module hsvbc_queue
    import hsvbc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_pix_entry    i_entry,
    input  logic          i_pop,
    output t_pix_entry    o_entry,
    output t_queue_status o_status
);

    t_pix_entry        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_status.empty = (r_count == '0);
        do_push        = i_push && !o_status.full;
        do_pop         = i_pop && !o_status.empty;
        o_entry        = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/hsvbc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, clamped result.
`timescale 1ns / 1ps
module hsvbc_div
    import hsvbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [QUO_W-1:0]   i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic               o_busy,
    output logic [CENT_W-1:0]  o_quotient
);

    logic               r_busy;
    logic [STEP_W-1:0]  r_steps;
    logic [COUNT_W-1:0] r_divisor;
    logic [COUNT_W-1:0] r_rem;
    logic [QUO_W-1:0]   r_quo;

    logic [COUNT_W:0]   rem_sh;
    logic               take;
    logic [COUNT_W:0]   rem_diff;

    always_comb begin
        rem_sh   = {r_rem, r_quo[QUO_W-1]};
        take     = rem_sh >= {1'b0, r_divisor};
        rem_diff = rem_sh - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_steps <= STEP_W'(QUO_W);
        end else if (r_busy) begin
            r_steps <= r_steps - 1'b1;
            if (r_steps == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Dividend bits shift out of the top while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= take ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], take};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = (r_quo[QUO_W-1:CENT_W] != '0) ? CENT_MAX : r_quo[CENT_W-1:0];

endmodule

// ===== rtl/hsvbc_back.sv =====
// Back end: match accumulation, end-of-frame division and result register.
`timescale 1ns / 1ps
module hsvbc_back
    import hsvbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pix_entry         i_entry,
    input  t_queue_status      i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COUNT_W-1:0] o_match_total,
    output logic [CENT_W-1:0]  o_centroid_row,
    output logic [CENT_W-1:0]  o_centroid_col,
    output logic [SUM_W-1:0]   o_last_color_sum,
    output logic               o_none_found
);

    t_back_state r_state, n_state;

    logic [COUNT_W-1:0] r_match_count, n_match_count;
    logic [ACC_W-1:0]   r_row_accum, n_row_accum;
    logic [ACC_W-1:0]   r_col_accum, n_col_accum;
    logic [SUM_W-1:0]   r_last_sum, n_last_sum;
    logic [COUNT_W-1:0] r_frame_count;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_total;
    logic [CENT_W-1:0]  r_out_row, r_out_col;
    logic [SUM_W-1:0]   r_out_sum;
    logic               r_out_none;

    logic               pop, hit, frame_end, div_start, out_load;
    logic [ACC_W:0]     row_sum, col_sum;
    logic               row_busy, col_busy;
    logic [CENT_W-1:0]  row_quo, col_quo;

    always_comb begin
        pop       = (r_state == BK_ACCUM) && !i_q_status.empty;
        hit       = pop && i_entry.hit;
        frame_end = pop && i_entry.eof;
        row_sum   = {1'b0, r_row_accum} + (ACC_W + 1)'(i_entry.row);
        col_sum   = {1'b0, r_col_accum} + (ACC_W + 1)'(i_entry.col);

        n_match_count = r_match_count;
        n_row_accum   = r_row_accum;
        n_col_accum   = r_col_accum;
        n_last_sum    = r_last_sum;
        if (hit) begin
            n_match_count = (r_match_count == COUNT_MAX) ? COUNT_MAX
                                                         : r_match_count + 1'b1;
            n_row_accum   = (row_sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX
                                                              : row_sum[ACC_W-1:0];
            n_col_accum   = (col_sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX
                                                              : col_sum[ACC_W-1:0];
            n_last_sum    = i_entry.color_sum;
        end

        div_start = frame_end && (n_match_count != '0);
        out_load  = (r_state == BK_OUT) && (!r_out_valid || i_ready);

        n_state = r_state;
        unique case (r_state)
            BK_ACCUM: if (frame_end) n_state = div_start ? BK_DIV : BK_OUT;
            BK_DIV:   if (!row_busy) n_state = BK_OUT;
            BK_OUT:   if (out_load) n_state = BK_ACCUM;
            default:  n_state = BK_ACCUM;
        endcase
    end

    hsvbc_div u_div_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({n_row_accum, FRAC_W'(0)}),
        .i_divisor  (n_match_count),
        .o_busy     (row_busy),
        .o_quotient (row_quo)
    );

    hsvbc_div u_div_col (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({n_col_accum, FRAC_W'(0)}),
        .i_divisor  (n_match_count),
        .o_busy     (col_busy),
        .o_quotient (col_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_ACCUM;
            r_match_count <= '0;
            r_row_accum   <= '0;
            r_col_accum   <= '0;
            r_last_sum    <= '0;
            r_frame_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_last_sum <= n_last_sum;
            if (frame_end) begin
                // Latch the frame total, clear for the next frame
                r_frame_count <= n_match_count;
                r_match_count <= '0;
                r_row_accum   <= '0;
                r_col_accum   <= '0;
            end else begin
                r_match_count <= n_match_count;
                r_row_accum   <= n_row_accum;
                r_col_accum   <= n_col_accum;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_total <= r_frame_count;
            r_out_none  <= (r_frame_count == '0);
            r_out_row   <= (r_frame_count == '0) ? '0 : row_quo;
            r_out_col   <= (r_frame_count == '0) ? '0 : col_quo;
            r_out_sum   <= r_last_sum;
        end
    end

    assign o_pop            = pop;
    assign o_valid          = r_out_valid;
    assign o_match_total    = r_out_total;
    assign o_centroid_row   = r_out_row;
    assign o_centroid_col   = r_out_col;
    assign o_last_color_sum = r_out_sum;
    assign o_none_found     = r_out_none;

`ifndef SYNTH
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_busy == col_busy)
        else $error("row and column dividers out of step");

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |=> (r_match_count == '0 && r_row_accum == '0 && r_col_accum == '0))
        else $error("accumulators not cleared after end of frame");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == BK_OUT))
        else $error("result loaded outside the output state");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_none) |->
            (r_out_total == '0 && r_out_row == '0 && r_out_col == '0))
        else $error("none-found result carries nonzero fields");
`endif

endmodule

// ===== rtl/hsv_window_blob_centroid.sv =====
// Top level of the HSV window blob centroid block.
`timescale 1ns / 1ps
// Color-window blob centroid. Each input beat is one HSV pixel with its row
// and column; tlast marks the last pixel of a frame. A pixel matches when hue,
// saturation and value each lie inside their inclusive window (config
// registers 0..5: hue low/high, sat low/high, val low/high, 8 bits each; a
// window with low above high matches nothing; writes to other indexes are
// ignored). Matches are counted and their row and column summed, with
// coordinates clamped to the frame size and count and sums saturating. The
// H+S+V of the latest match is kept across frames. On the end-of-frame pixel
// one result beat carries the count, both centroids (floor of sum*16/count,
// 4 fraction bits, clamped to 16383), that color sum, and a none-found flag in
// tuser (centroids 0 then); the count and sums then restart. Rate: one pixel
// per clock while a frame streams in. The end-of-frame pixel starts two
// bit-serial dividers that produce one quotient bit per cycle; the output
// state then loads their quotients into the result register; a frame with no
// match skips the division. A four-entry pixel queue between the classifier
// and the accumulator keeps tready high during the first cycles of that
// division, after which the input stalls until the result is loaded. The
// result register lets the next frame stream in while a result waits.
module hsv_window_blob_centroid
    import hsvbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [PIX_W-1:0]      i_cfg_wdata,
    // pixel stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // hue[7:0], sat[15:8], val[23:16], row[33:24], col[43:34], zeros[47:44]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // match_total[20:0], centroid_row[34:21], centroid_col[48:35],
    // last_color_sum[58:49], zeros[63:59]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // none_found[0]
    output logic                  o_m_axis_tuser
);

    localparam int OUT_USED_W = COUNT_W + 2 * CENT_W + SUM_W;

    t_queue_status      q_status;
    t_pix_entry         push_entry, head_entry;
    logic               push, pop;
    logic [COUNT_W-1:0] match_total;
    logic [CENT_W-1:0]  centroid_row, centroid_col;
    logic [SUM_W-1:0]   last_color_sum;

    hsvbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_hue       (i_s_axis_tdata[7:0]),
        .i_sat       (i_s_axis_tdata[15:8]),
        .i_val       (i_s_axis_tdata[23:16]),
        .i_row       (i_s_axis_tdata[33:24]),
        .i_col       (i_s_axis_tdata[43:34]),
        .i_eof       (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    hsvbc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    hsvbc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (head_entry),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_match_total    (match_total),
        .o_centroid_row   (centroid_row),
        .o_centroid_col   (centroid_col),
        .o_last_color_sum (last_color_sum),
        .o_none_found     (o_m_axis_tuser)
    );

    // Pack result fields, lowest field in the lowest bits
    assign o_m_axis_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), last_color_sum,
                             centroid_col, centroid_row, match_total};

endmodule
